// File: rtl/bmm_pkg.sv
// ----------------------------------------------------------------------------
// bmm_pkg: shared types and constants of the banked memory mapper
// Bus access codes, target codes, the bank table constants and the item and
// result records passed between the top level and the translation logic.
// ----------------------------------------------------------------------------
package bmm_pkg;

	localparam int ADDR_W      = 16;
	localparam int DATA_W      = 8;
	localparam int BANK_W      = 6;
	localparam int PHYS_W      = 19;
	localparam int TILE_W      = 10;
	localparam int TILE_SHIFT  = 3;
	localparam int KANJI_OFF_W = 11;    // 0x800 byte kanji window
	localparam int KANJI_SEL_W = 7;     // kanji_select & 0x7f picks the window

	localparam logic [BANK_W-1:0] SPECIAL_BANK = 6'h39;
	localparam logic [BANK_W-1:0] BANK_MASK    = 6'h3f;
	localparam int                KANJI_ON_BIT = 7;

	typedef enum logic [2:0] {
		MODE_MEM_RD    = 3'd0,
		MODE_MEM_WR    = 3'd1,
		MODE_IDX_WR    = 3'd2,
		MODE_IDX_RD    = 3'd3,
		MODE_TBL_WR    = 3'd4,
		MODE_TBL_RD    = 3'd5,
		MODE_KANJI_WR  = 3'd6
	} mode_t;

	typedef enum logic [1:0] {
		TGT_MAIN  = 2'd0,
		TGT_KANJI = 2'd1,
		TGT_PCG   = 2'd2,
		TGT_NONE  = 2'd3
	} target_t;

	typedef struct packed {
		logic [2:0]        mode;
		logic [ADDR_W-1:0] cpu_addr;
		logic [DATA_W-1:0] write_data;
	} item_t;

	typedef struct packed {
		target_t           target;
		logic [PHYS_W-1:0] phys_addr;
		logic              mem_write;
		logic [DATA_W-1:0] mem_wdata;
		logic [DATA_W-1:0] reg_rdata;
		logic              dirty_valid;
		logic [TILE_W-1:0] dirty_tile;
	} result_t;

endpackage

// File: rtl/bmm_in_if.sv
// ----------------------------------------------------------------------------
// bmm_in_if: bus access channel
// Valid/ready channel carrying one CPU bus access per transfer.
// ----------------------------------------------------------------------------
interface bmm_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  mode;
	logic [15:0] cpu_addr;
	logic [7:0]  write_data;

	modport source (output valid, output mode, output cpu_addr, output write_data,
		input ready);
	modport sink (input valid, input mode, input cpu_addr, input write_data,
		output ready);
endinterface

// File: rtl/bmm_out_if.sv
// ----------------------------------------------------------------------------
// bmm_out_if: translated access channel
// Valid/ready channel carrying one translated bus access per transfer.
// ----------------------------------------------------------------------------
interface bmm_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  target;
	logic [18:0] phys_addr;
	logic        mem_write;
	logic [7:0]  mem_wdata;
	logic [7:0]  reg_rdata;
	logic        dirty_valid;
	logic [9:0]  dirty_tile;

	modport source (output valid, output target, output phys_addr, output mem_write,
		output mem_wdata, output reg_rdata, output dirty_valid, output dirty_tile,
		input ready);
	modport sink (input valid, input target, input phys_addr, input mem_write,
		input mem_wdata, input reg_rdata, input dirty_valid, input dirty_tile,
		output ready);
endinterface

// File: rtl/bmm_xlate.sv
// ----------------------------------------------------------------------------
// bmm_xlate: address translation of one bus access
// Turns an access plus the selected bank entry, bank index and kanji select
// into the result record. Purely combinational.
// ----------------------------------------------------------------------------
module bmm_xlate #(
	parameter int WINDOW_BITS = 13
) (
	input  bmm_pkg::item_t                  item,
	input  logic [bmm_pkg::BANK_W-1:0]      bank,
	input  logic [bmm_pkg::DATA_W-1:0]      index_rd,
	input  logic [bmm_pkg::DATA_W-1:0]      kanji_select,
	output bmm_pkg::result_t                res
);

	localparam int                          MAIN_W   = bmm_pkg::BANK_W + WINDOW_BITS;
	localparam logic [bmm_pkg::ADDR_W-1:0]  OFF_MASK =
		bmm_pkg::ADDR_W'((32'd1 << WINDOW_BITS) - 32'd1);

	logic [bmm_pkg::ADDR_W-1:0] off16;
	logic [MAIN_W-1:0]          main_full;
	logic [bmm_pkg::PHYS_W-1:0] kanji_phys;
	logic                       wr;

	assign off16      = item.cpu_addr & OFF_MASK;
	assign main_full  = {bank, off16[WINDOW_BITS-1:0]};
	// Window base is a multiple of 0x800, so the add is a plain concatenation.
	assign kanji_phys = bmm_pkg::PHYS_W'({kanji_select[bmm_pkg::KANJI_SEL_W-1:0],
		off16[bmm_pkg::KANJI_OFF_W-1:0]});
	assign wr         = (bmm_pkg::mode_t'(item.mode) == bmm_pkg::MODE_MEM_WR);

	always_comb begin
		res = '0;
		res.target = bmm_pkg::TGT_NONE;
		case (bmm_pkg::mode_t'(item.mode))
			bmm_pkg::MODE_MEM_RD, bmm_pkg::MODE_MEM_WR: begin
				if (bank == bmm_pkg::SPECIAL_BANK) begin
					if (kanji_select[bmm_pkg::KANJI_ON_BIT]) begin
						// kanji ROM is read only: drop writes
						if (!wr) begin
							res.target    = bmm_pkg::TGT_KANJI;
							res.phys_addr = kanji_phys;
						end
					end else begin
						res.target    = bmm_pkg::TGT_PCG;
						res.phys_addr = bmm_pkg::PHYS_W'(off16);
						if (wr) begin
							res.mem_write   = 1'b1;
							res.mem_wdata   = item.write_data;
							res.dirty_valid = 1'b1;
							res.dirty_tile  = off16[bmm_pkg::TILE_SHIFT +: bmm_pkg::TILE_W];
						end
					end
				end else begin
					res.target    = bmm_pkg::TGT_MAIN;
					res.phys_addr = bmm_pkg::PHYS_W'(main_full);
					if (wr) begin
						res.mem_write = 1'b1;
						res.mem_wdata = item.write_data;
					end
				end
			end
			bmm_pkg::MODE_IDX_RD, bmm_pkg::MODE_TBL_RD: begin
				res.reg_rdata = (bmm_pkg::mode_t'(item.mode) == bmm_pkg::MODE_IDX_RD) ?
					index_rd : bmm_pkg::DATA_W'(bank);
			end
			default: begin
				res.target = bmm_pkg::TGT_NONE;
			end
		endcase
	end

endmodule

// File: rtl/banked_memory_mapper.sv
// ----------------------------------------------------------------------------
// banked_memory_mapper: bank mapper for an 8-bit CPU
// Translates CPU bus accesses through a bank table into main RAM, kanji ROM
// or PCG RAM addresses, and serves the bank index and table ports.
// ----------------------------------------------------------------------------
// One access is taken per clock cycle while the output is not stalled. Each
// access lands in an input register, the table lookup and address build run in
// one short combinational pass, and the result sits in an output register from
// which it is offered on the output. The bank table, bank index and kanji
// select are read and updated in that same pass, so back-to-back table writes
// and memory accesses see each other in order with no gaps. The output register
// frees as its result is taken, so a new access is accepted in the same cycle a
// result transfers; only a result that is not taken stalls the input. No
// clearing pass after reset: the bank table resets to entry i holding i at once.
// ----------------------------------------------------------------------------
module banked_memory_mapper #(
	parameter int NUM_WINDOWS = 8,
	parameter int WINDOW_BITS = 13
) (
	input  logic      clk,
	input  logic      arst_n,
	bmm_in_if.sink    bus_ch,
	bmm_out_if.source map_ch
);

	localparam int IDX_W = $clog2(NUM_WINDOWS);
	// Window select bits above the offset; keep at least one bit for indexing.
	localparam int HI_W  = (WINDOW_BITS < bmm_pkg::ADDR_W) ?
		(bmm_pkg::ADDR_W - WINDOW_BITS) : 1;
	localparam int HI_N  = 1 << HI_W;
	localparam int DAT_N = 1 << bmm_pkg::DATA_W;

	// Constant tables for the modulo-NUM_WINDOWS reductions.
	logic [IDX_W-1:0] win_lut [HI_N];
	logic [IDX_W-1:0] idx_lut [DAT_N];

	for (genvar g = 0; g < HI_N; g++) begin : g_win_lut
		assign win_lut[g] = IDX_W'(g % NUM_WINDOWS);
	end
	for (genvar g = 0; g < DAT_N; g++) begin : g_idx_lut
		assign idx_lut[g] = IDX_W'(g % NUM_WINDOWS);
	end

	// Input register stage
	logic            valid_s1;
	bmm_pkg::item_t  item_s1;
	logic            advance_s1;

	// Output register
	logic             out_valid_q;
	bmm_pkg::result_t result_q;

	// Mapper state
	logic [bmm_pkg::BANK_W-1:0] bank_table_q [NUM_WINDOWS];
	logic [IDX_W-1:0]           bank_index_q;
	logic [bmm_pkg::DATA_W-1:0] kanji_select_q;

	logic [bmm_pkg::ADDR_W-1:0] addr_hi;
	logic [IDX_W-1:0]           win;
	logic [IDX_W-1:0]           rd_idx;
	logic [IDX_W-1:0]           idx_inc;
	logic [bmm_pkg::BANK_W-1:0] bank_rd;
	logic                       is_mem;
	bmm_pkg::result_t           res_s1;

	// Stage 1 moves on when the output register is empty or being drained.
	assign advance_s1   = valid_s1 && (!out_valid_q || map_ch.ready);
	assign bus_ch.ready = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bus_ch.ready) begin
			valid_s1 <= bus_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bus_ch.ready && bus_ch.valid) begin
			item_s1.mode       <= bus_ch.mode;
			item_s1.cpu_addr   <= bus_ch.cpu_addr;
			item_s1.write_data <= bus_ch.write_data;
		end
	end

	// Window select, then one shared read port on the bank table: memory
	// accesses look up their window, table reads use the bank index.
	assign addr_hi = item_s1.cpu_addr >> WINDOW_BITS;
	assign win     = win_lut[addr_hi[HI_W-1:0]];
	always_comb begin
		is_mem = bmm_pkg::mode_t'(item_s1.mode) inside {bmm_pkg::MODE_MEM_RD,
			bmm_pkg::MODE_MEM_WR};
	end
	assign rd_idx  = is_mem ? win : bank_index_q;
	assign bank_rd = bank_table_q[rd_idx];

	// Index auto-increment, wrapping at NUM_WINDOWS.
	assign idx_inc = (bank_index_q == IDX_W'(NUM_WINDOWS - 1)) ? '0 :
		bank_index_q + IDX_W'(1);

	bmm_xlate #(
		.WINDOW_BITS (WINDOW_BITS)
	) u_xlate (
		.item         (item_s1),
		.bank         (bank_rd),
		.index_rd     (bmm_pkg::DATA_W'(bank_index_q)),
		.kanji_select (kanji_select_q),
		.res          (res_s1)
	);

	// Update mapper state as the access leaves stage 1.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_WINDOWS; i++) begin
				bank_table_q[i] <= bmm_pkg::BANK_W'(i) & bmm_pkg::BANK_MASK;
			end
			bank_index_q   <= '0;
			kanji_select_q <= '0;
		end else if (advance_s1) begin
			case (bmm_pkg::mode_t'(item_s1.mode))
				bmm_pkg::MODE_IDX_WR: begin
					bank_index_q <= idx_lut[item_s1.write_data];
				end
				bmm_pkg::MODE_TBL_WR: begin
					bank_table_q[bank_index_q] <=
						item_s1.write_data[bmm_pkg::BANK_W-1:0] & bmm_pkg::BANK_MASK;
					bank_index_q <= idx_inc;
				end
				bmm_pkg::MODE_TBL_RD: begin
					bank_index_q <= idx_inc;
				end
				bmm_pkg::MODE_KANJI_WR: begin
					kanji_select_q <= item_s1.write_data;
				end
				default: begin
					// memory accesses, index reads and the unused code change no state
				end
			endcase
		end
	end

	// Output register: load on advance, drop once the result transfers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1) begin
			out_valid_q <= 1'b1;
		end else if (map_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1) begin
			result_q <= res_s1;
		end
	end

	assign map_ch.valid       = out_valid_q;
	assign map_ch.target      = result_q.target;
	assign map_ch.phys_addr   = result_q.phys_addr;
	assign map_ch.mem_write   = result_q.mem_write;
	assign map_ch.mem_wdata   = result_q.mem_wdata;
	assign map_ch.reg_rdata   = result_q.reg_rdata;
	assign map_ch.dirty_valid = result_q.dirty_valid;
	assign map_ch.dirty_tile  = result_q.dirty_tile;

	// The bank index never leaves the table.
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		bank_index_q <= IDX_W'(NUM_WINDOWS - 1))
		else $error("bank index out of range");

	// A dirty tile only comes from a PCG RAM write.
	a_dirty_pcg: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && result_q.dirty_valid) |->
		(result_q.target == bmm_pkg::TGT_PCG && result_q.mem_write))
		else $error("dirty tile without PCG write");

	// Kanji ROM and register port accesses never write memory.
	a_no_rom_write: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && result_q.mem_write) |->
		(result_q.target == bmm_pkg::TGT_MAIN || result_q.target == bmm_pkg::TGT_PCG))
		else $error("memory write to kanji ROM or register port");

	// Stage 1 is never overwritten while it holds an access that cannot move.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance_s1) |=> (valid_s1 && $stable(item_s1)))
		else $error("stalled access lost in stage 1");

endmodule

// File: bench/banked_memory_mapper_tb.sv
// ----------------------------------------------------------------------------
// banked_memory_mapper_tb: self-checking bench for the bank mapper
// Drives CPU bus accesses through the input channel and checks every
// translated access against a mirror of the bank table, bank index and kanji
// select kept in this bench. Directed accesses cover reset mapping, the
// register ports and the special bank. Random traffic follows, with random
// gaps on both sides, a long output freeze and pauses that let results drain.
// ----------------------------------------------------------------------------
module banked_memory_mapper_tb;

	localparam int NUM_WIN  = 8;
	localparam int WIN_BITS = 13;

	// Mode 3'd7 has no meaning to the block; it must still translate to nothing.
	localparam logic [2:0] MODE_UNUSED = 3'd7;

	localparam logic [31:0] KANJI_WIN_MASK = 32'h7ff;
	localparam logic [31:0] KANJI_STRIDE   = 32'h800;
	localparam logic [31:0] KANJI_SEL_MASK = 32'h7f;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int HOLD_CYCLES  = 150;    // long output freeze
	localparam int TAIL_CYCLES  = 8;      // margin for results still in flight

	logic clk = 1'b0;
	logic arst_n;

	bmm_in_if  bus_ch ();
	bmm_out_if map_ch ();

	banked_memory_mapper #(
		.NUM_WINDOWS(NUM_WIN),
		.WINDOW_BITS(WIN_BITS)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.bus_ch(bus_ch),
		.map_ch(map_ch)
	);

	always #5 clk = ~clk;

	// Mirror of the mapper state, advanced once per accepted access.
	logic [bmm_pkg::BANK_W-1:0] mirror_bank [NUM_WIN];
	int unsigned                mirror_index;
	logic [7:0]                 mirror_kanji;

	bmm_pkg::result_t due_xlat_q[$];    // translations still owed by the block
	int unsigned mismatch_count   = 0;
	int unsigned accesses_sent    = 0;
	int unsigned xlats_checked    = 0;
	int unsigned pcg_dirty_seen   = 0;
	int unsigned kanji_reads_seen = 0;
	int unsigned cycle_count      = 0;

	bit src_idle_en  = 1'b1;   // random gaps between transfers on the input
	bit sink_idle_en = 1'b1;   // random stalls on the output
	bit hold_req     = 1'b0;   // ask the sink for one long freeze
	bit sink_holding = 1'b0;

	function automatic void reset_mirror();
		for (int i = 0; i < NUM_WIN; i++)
			mirror_bank[i] = bmm_pkg::BANK_W'(i);
		mirror_index = 0;
		mirror_kanji = '0;
	endfunction

	// Translate one bus access and update the mirror exactly as the block does.
	function automatic bmm_pkg::result_t translate_access(bmm_pkg::item_t acc);
		bmm_pkg::result_t           xl;
		logic [WIN_BITS-1:0]        offset;
		int unsigned                win;
		logic [bmm_pkg::BANK_W-1:0] bank;
		logic [31:0]                span;
		xl        = '0;
		xl.target = bmm_pkg::TGT_NONE;
		win       = (int'(acc.cpu_addr) >> WIN_BITS) % NUM_WIN;
		offset    = acc.cpu_addr[WIN_BITS-1:0];
		case (acc.mode)
		bmm_pkg::MODE_MEM_RD, bmm_pkg::MODE_MEM_WR: begin
			bank = mirror_bank[win];
			if (bank == bmm_pkg::SPECIAL_BANK) begin
				if (mirror_kanji[bmm_pkg::KANJI_ON_BIT]) begin
					// kanji ROM is read only: a write there translates to nothing
					if (acc.mode == bmm_pkg::MODE_MEM_RD) begin
						xl.target    = bmm_pkg::TGT_KANJI;
						span         = (32'(offset) & KANJI_WIN_MASK)
							+ (32'(mirror_kanji) & KANJI_SEL_MASK) * KANJI_STRIDE;
						xl.phys_addr = span[bmm_pkg::PHYS_W-1:0];
					end
				end else begin
					xl.target    = bmm_pkg::TGT_PCG;
					xl.phys_addr = bmm_pkg::PHYS_W'(offset);
					if (acc.mode == bmm_pkg::MODE_MEM_WR) begin
						xl.mem_write   = 1'b1;
						xl.mem_wdata   = acc.write_data;
						xl.dirty_valid = 1'b1;
						xl.dirty_tile  = bmm_pkg::TILE_W'(offset >> bmm_pkg::TILE_SHIFT);
					end
				end
			end else begin
				xl.target    = bmm_pkg::TGT_MAIN;
				span         = (32'(bank) << WIN_BITS) | 32'(offset);
				xl.phys_addr = span[bmm_pkg::PHYS_W-1:0];
				if (acc.mode == bmm_pkg::MODE_MEM_WR) begin
					xl.mem_write = 1'b1;
					xl.mem_wdata = acc.write_data;
				end
			end
		end
		bmm_pkg::MODE_IDX_WR: mirror_index = acc.write_data % NUM_WIN;
		bmm_pkg::MODE_IDX_RD: xl.reg_rdata = 8'(mirror_index);
		bmm_pkg::MODE_TBL_WR: begin
			mirror_bank[mirror_index] =
				acc.write_data[bmm_pkg::BANK_W-1:0] & bmm_pkg::BANK_MASK;
			mirror_index = (mirror_index + 1) % NUM_WIN;
		end
		bmm_pkg::MODE_TBL_RD: begin
			xl.reg_rdata = 8'(mirror_bank[mirror_index]);
			mirror_index = (mirror_index + 1) % NUM_WIN;
		end
		bmm_pkg::MODE_KANJI_WR: mirror_kanji = acc.write_data;
		default: ;
		endcase
		return xl;
	endfunction

	task automatic report_error(string msg);
		mismatch_count++;
		$display("ERROR @%0t: %s", $time, msg);
	endtask

	task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report_error($sformatf("translation %0d: %s is 0x%0h, expected 0x%0h",
				xlats_checked, name, got, want));
	endtask

	// Predict on the input transfer first, then check the output transfer, all
	// in one process so that ordering within the edge never matters.
	always @(posedge clk) begin : scoreboard
		bmm_pkg::item_t   acc;
		bmm_pkg::result_t want;
		if (arst_n) begin
			if (bus_ch.valid && bus_ch.ready === 1'b1) begin
				acc.mode       = bus_ch.mode;
				acc.cpu_addr   = bus_ch.cpu_addr;
				acc.write_data = bus_ch.write_data;
				due_xlat_q.push_back(translate_access(acc));
			end
			if (map_ch.valid === 1'b1 && map_ch.ready) begin
				if (due_xlat_q.size() == 0) begin
					report_error("translated access with nothing outstanding");
				end else begin
					want = due_xlat_q.pop_front();
					check_field("target", map_ch.target, want.target);
					check_field("phys_addr", map_ch.phys_addr, want.phys_addr);
					check_field("mem_write", map_ch.mem_write, want.mem_write);
					check_field("mem_wdata", map_ch.mem_wdata, want.mem_wdata);
					check_field("reg_rdata", map_ch.reg_rdata, want.reg_rdata);
					check_field("dirty_valid", map_ch.dirty_valid, want.dirty_valid);
					check_field("dirty_tile", map_ch.dirty_tile, want.dirty_tile);
					if (want.target == bmm_pkg::TGT_KANJI)
						kanji_reads_seen++;
					if (want.dirty_valid)
						pcg_dirty_seen++;
					xlats_checked++;
				end
			end
		end
	end

	// Abort a hung run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d translations outstanding",
				cycle_count, due_xlat_q.size());
			$display("status: fail");
			$finish;
		end
	end

	// Output side: stall at random, or hold ready low for one long stretch on
	// request, counting the cycles here.
	initial begin : result_sink
		int unsigned r, len;
		map_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req     = 1'b0;
				sink_holding = 1'b1;
				map_ch.ready <= 1'b0;
				for (int n = 0; n < HOLD_CYCLES; n++)
					@(negedge clk);
				sink_holding = 1'b0;
				map_ch.ready <= 1'b1;
			end else if (!sink_idle_en) begin
				map_ch.ready <= 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 65) begin
					map_ch.ready <= 1'b1;
					len = $urandom_range(1, 8);
				end else begin
					map_ch.ready <= 1'b0;
					len = (r < 94) ? $urandom_range(1, 3) : $urandom_range(10, 40);
				end
				repeat (len - 1) @(negedge clk);
			end
		end
	end

	// Leave a random gap after a transfer: drop valid and scramble the payload.
	task automatic source_gap();
		int unsigned r, len;
		r = $urandom_range(0, 99);
		if (r < 60)
			len = 0;
		else if (r < 93)
			len = $urandom_range(1, 3);
		else
			len = $urandom_range(10, 40);
		if (len != 0) begin
			bus_ch.valid      <= 1'b0;
			bus_ch.mode       <= 3'($urandom);
			bus_ch.cpu_addr   <= 16'($urandom);
			bus_ch.write_data <= 8'($urandom);
			repeat (len) @(negedge clk);
		end
	endtask

	// Offer one access and hold it until the transfer; called at a falling edge,
	// returns at a falling edge with valid still high unless a gap follows.
	task automatic send_access(logic [2:0] mode, logic [15:0] addr, logic [7:0] data);
		bus_ch.mode       <= mode;
		bus_ch.cpu_addr   <= addr;
		bus_ch.write_data <= data;
		bus_ch.valid      <= 1'b1;
		do
			@(posedge clk);
		while (bus_ch.ready !== 1'b1);
		@(negedge clk);
		accesses_sent++;
		if (src_idle_en)
			source_gap();
	endtask

	// Drop valid, then wait at falling edges until every result is back.
	task automatic wait_results_done();
		bus_ch.valid <= 1'b0;
		do
			@(negedge clk);
		while (due_xlat_q.size() != 0);
	endtask

	// Table value for random reprogramming: the special bank often, upper bits
	// of the byte random so the mask is exercised.
	function automatic logic [7:0] random_bank_byte();
		if ($urandom_range(0, 99) < 40)
			return {2'($urandom), bmm_pkg::SPECIAL_BANK};
		return 8'($urandom);
	endfunction

	task automatic test_reset_mapping();
		send_access(bmm_pkg::MODE_MEM_RD, 16'h0000, 8'hff);
		send_access(bmm_pkg::MODE_MEM_WR, 16'hffff, 8'hff);
		send_access(MODE_UNUSED, 16'hffff, 8'hff);
		send_access(bmm_pkg::MODE_IDX_RD, 16'hffff, 8'h00);
		wait_results_done();
	endtask

	task automatic test_bank_ports();
		send_access(bmm_pkg::MODE_IDX_WR, 16'h0000, 8'hff);   // index takes 0xff mod 8
		send_access(bmm_pkg::MODE_TBL_RD, 16'h0000, 8'h00);   // entry 7, index wraps to 0
		send_access(bmm_pkg::MODE_TBL_WR, 16'h0000, 8'hff);   // entry 0 takes 0x3f
		send_access(bmm_pkg::MODE_IDX_WR, 16'h0000, 8'h00);
		send_access(bmm_pkg::MODE_TBL_RD, 16'h0000, 8'h00);
		send_access(bmm_pkg::MODE_MEM_WR, 16'h1234, 8'h00);   // top bank of main RAM
		wait_results_done();
	endtask

	task automatic test_special_bank();
		send_access(bmm_pkg::MODE_IDX_WR, 16'h0000, 8'h03);
		send_access(bmm_pkg::MODE_TBL_WR, 16'h0000, {2'b00, bmm_pkg::SPECIAL_BANK});
		send_access(bmm_pkg::MODE_MEM_RD, 16'h7fff, 8'h00);   // PCG read, top offset
		send_access(bmm_pkg::MODE_MEM_WR, 16'h7fff, 8'ha5);   // top dirty tile
		send_access(bmm_pkg::MODE_MEM_WR, 16'h6000, 8'h5a);   // dirty tile zero
		send_access(bmm_pkg::MODE_KANJI_WR, 16'h0000, 8'hff);
		send_access(bmm_pkg::MODE_MEM_RD, 16'h7fff, 8'h00);   // last byte, top kanji window
		send_access(bmm_pkg::MODE_MEM_WR, 16'h6001, 8'h33);   // dropped ROM write
		send_access(bmm_pkg::MODE_KANJI_WR, 16'h0000, 8'h80);
		send_access(bmm_pkg::MODE_MEM_RD, 16'h6800, 8'h00);   // kanji offset wraps at 0x800
		send_access(bmm_pkg::MODE_KANJI_WR, 16'h0000, 8'h7f); // bit 7 clear: back to PCG
		send_access(bmm_pkg::MODE_MEM_RD, 16'h6008, 8'h00);
		wait_results_done();
	endtask

	// Mostly memory traffic, with table reprogramming bursts, table read bursts
	// and kanji select flips mixed in.
	task automatic test_random_traffic(int unsigned n);
		int unsigned done, r, burst;
		done = 0;
		while (done < n) begin
			r = $urandom_range(0, 99);
			if (r < 32) begin
				send_access(bmm_pkg::MODE_MEM_RD, 16'($urandom), 8'($urandom));
				done++;
			end else if (r < 58) begin
				send_access(bmm_pkg::MODE_MEM_WR, 16'($urandom), 8'($urandom));
				done++;
			end else if (r < 66) begin
				burst = $urandom_range(1, 8);
				send_access(bmm_pkg::MODE_IDX_WR, 16'($urandom), 8'($urandom));
				repeat (burst)
					send_access(bmm_pkg::MODE_TBL_WR, 16'($urandom), random_bank_byte());
				done += burst + 1;
			end else if (r < 72) begin
				burst = $urandom_range(1, 9);
				repeat (burst)
					send_access(bmm_pkg::MODE_TBL_RD, 16'($urandom), 8'($urandom));
				done += burst;
			end else if (r < 78) begin
				send_access(bmm_pkg::MODE_IDX_RD, 16'($urandom), 8'($urandom));
				done++;
			end else if (r < 88) begin
				send_access(bmm_pkg::MODE_KANJI_WR, 16'($urandom), 8'($urandom));
				done++;
			end else if (r < 92) begin
				send_access(MODE_UNUSED, 16'($urandom), 8'($urandom));
				done++;
			end else begin
				send_access(bmm_pkg::MODE_IDX_WR, 16'($urandom), 8'($urandom));
				done++;
			end
		end
	endtask

	// No idling on either side: one transfer per cycle end to end.
	task automatic test_streaming();
		src_idle_en  = 1'b0;
		sink_idle_en = 1'b0;
		test_random_traffic(220);
		wait_results_done();
		src_idle_en  = 1'b1;
		sink_idle_en = 1'b1;
	endtask

	// Freeze the output long enough that the block fills and stalls its input,
	// while accesses keep coming back to back.
	task automatic test_backpressure();
		src_idle_en  = 1'b0;
		sink_idle_en = 1'b0;
		hold_req     = 1'b1;
		wait (sink_holding);
		test_random_traffic(40);
		wait_results_done();
		src_idle_en  = 1'b1;
		sink_idle_en = 1'b1;
	endtask

	// Short bursts, each followed by a pause until every result is back.
	task automatic test_drain_pauses();
		repeat (5) begin
			test_random_traffic(30);
			wait_results_done();
		end
	endtask

	initial begin : stimulus
		bus_ch.valid      = 1'b0;
		bus_ch.mode       = '0;
		bus_ch.cpu_addr   = '0;
		bus_ch.write_data = '0;
		arst_n            = 1'b0;
		reset_mirror();
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_mapping();
		test_bank_ports();
		test_special_bank();
		test_random_traffic(450);
		wait_results_done();
		test_streaming();
		test_backpressure();
		test_drain_pauses();
		test_random_traffic(400);

		// Let the pipeline empty, then give stray results a chance to show.
		wait_results_done();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (due_xlat_q.size() != 0)
			report_error($sformatf("%0d translations never arrived", due_xlat_q.size()));

		$display("ran %0d bus accesses, checked %0d translations in %0d cycles",
			accesses_sent, xlats_checked, cycle_count);
		$display("saw %0d PCG dirty writes and %0d kanji ROM reads, %0d mismatches",
			pcg_dirty_seen, kanji_reads_seen, mismatch_count);
		if (mismatch_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
